[hw/rtl/sdr_pkg.sv]
// Constants and codes shared by the shaded disc rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package sdr_pkg;

	localparam logic [6:0]  MAX_RADIUS = 7'd96;
	localparam logic [11:0] MAX_FRAME  = 12'd2048;

	localparam logic        CMD_LOAD = 1'b0;
	localparam logic        CMD_STEP = 1'b1;

	localparam logic [1:0]  CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0]  CFG_FRAME_HEIGHT = 2'd1;

	localparam logic [11:0] FRAME_WIDTH_RST  = 12'd320;
	localparam logic [11:0] FRAME_HEIGHT_RST = 12'd180;

	localparam logic [16:0] SH_BASE = 17'd34079;
	localparam logic [15:0] SH_GAIN = 16'd31457;
	localparam logic [16:0] ST_BASE = 17'd57672;
	localparam logic [15:0] ST_GAIN = 16'd7864;
	localparam logic [24:0] RND_HALF = 25'd32768;

	localparam logic [4:0]  LAST_STEP = 5'd22;

endpackage

`default_nettype wire

[hw/rtl/shaded_disc_rasterizer_core.sv]
// Shaded disc rasterizer: box scan, bit-serial square root and divide, color shading.
//
// A load command latches a body; its result passes through the done state into
// the output register. A step on an idle scan goes straight to the done state,
// and one whose box position is off-frame or outside the disc goes there from
// the check after the multiplies. For a step that writes a pixel, one shared
// multiplier forms r*r - dx*dx - dy*dy, a digit-serial square root retires two
// radicand bits per cycle, a restoring divide by the radius takes one quotient
// bit per cycle, and the same multiplier then forms the shade (scaled again for
// a star) and the three channels one per cycle. One item is in work at a time;
// a finished result sits in the output register while the next item is taken.
// Configuration writes are always ready.
`timescale 1ns / 1ps
`default_nettype none

module shaded_disc_rasterizer_core import sdr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [11:0]        cfg_data,

	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               cmd,
	input  wire logic signed [12:0] ctr_x,
	input  wire logic signed [12:0] ctr_y,
	input  wire logic [6:0]         disc_radius,
	input  wire logic               is_star,
	input  wire logic [7:0]         red,
	input  wire logic [7:0]         green,
	input  wire logic [7:0]         blue,

	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    write_enable,
	output logic [10:0]             pixel_x,
	output logic [10:0]             pixel_y,
	output logic [7:0]              out_red,
	output logic [7:0]              out_green,
	output logic [7:0]              out_blue,
	output logic                    star_pixel,
	output logic                    finished
);

	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_R2   = 4'd1;
	localparam logic [3:0] PH_DX2  = 4'd2;
	localparam logic [3:0] PH_DY2  = 4'd3;
	localparam logic [3:0] PH_CHK  = 4'd4;
	localparam logic [3:0] PH_SQRT = 4'd5;
	localparam logic [3:0] PH_DIV  = 4'd6;
	localparam logic [3:0] PH_SH   = 4'd7;
	localparam logic [3:0] PH_ST   = 4'd8;
	localparam logic [3:0] PH_CR   = 4'd9;
	localparam logic [3:0] PH_CG   = 4'd10;
	localparam logic [3:0] PH_CB   = 4'd11;
	localparam logic [3:0] PH_DONE = 4'd12;

	logic [3:0]         phase_q;
	logic [11:0]        frame_width_q;
	logic [11:0]        frame_height_q;
	logic [7:0]         scan_col_q;
	logic [7:0]         scan_row_q;
	logic [12:0]        body_col_q;
	logic [12:0]        body_row_q;
	logic [6:0]         body_radius_q;
	logic               body_star_q;
	logic [7:0]         body_red_q;
	logic [7:0]         body_green_q;
	logic [7:0]         body_blue_q;
	logic               scan_active_q;

	logic [6:0]         dx_q;
	logic [6:0]         dy_q;
	logic               inframe_q;
	logic signed [15:0] acc_q;
	logic [45:0]        rad_q;
	logic [25:0]        sq_rem_q;
	logic [22:0]        root_q;
	logic [22:0]        div_q;
	logic [6:0]         dv_rem_q;
	logic [4:0]         cnt_q;
	logic [16:0]        shade_q;

	logic               res_we_q;
	logic               res_fin_q;
	logic [10:0]        res_x_q;
	logic [10:0]        res_y_q;
	logic [7:0]         res_red_q;
	logic [7:0]         res_green_q;
	logic [7:0]         res_blue_q;

	logic               out_valid_q;
	logic               write_enable_q;
	logic [10:0]        pixel_x_q;
	logic [10:0]        pixel_y_q;
	logic [7:0]         out_red_q;
	logic [7:0]         out_green_q;
	logic [7:0]         out_blue_q;
	logic               star_pixel_q;
	logic               finished_q;

	logic [11:0]        w_eff;
	logic [11:0]        h_eff;
	logic [6:0]         r_sat;
	logic signed [14:0] cx_s;
	logic signed [14:0] cy_s;
	logic signed [14:0] rs_s;
	logic signed [14:0] ws_s;
	logic signed [14:0] hs_s;
	logic               cull;
	logic signed [8:0]  dx_s;
	logic signed [8:0]  dy_s;
	logic [13:0]        x_s;
	logic [13:0]        y_s;
	logic               x_in;
	logic               y_in;
	logic [6:0]         adx;
	logic [6:0]         ady;
	logic               col_last;
	logic               row_last;

	logic [16:0]        mul_a;
	logic [15:0]        mul_b;
	logic [32:0]        mul_p;
	logic [25:0]        sq_rem_n;
	logic [25:0]        sq_trial;
	logic               sq_ge;
	logic [22:0]        root_n;
	logic [7:0]         dv_rem_n;
	logic               dv_ge;
	logic [22:0]        div_n;
	logic [24:0]        ch_sum;
	logic [7:0]         ch_val;

	logic               in_take;
	logic               out_take;
	logic               out_load;

	assign cfg_ready = 1'b1;
	assign in_stall  = (phase_q != PH_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_load  = (phase_q == PH_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		w_eff = (frame_width_q > MAX_FRAME) ? MAX_FRAME : frame_width_q;
		h_eff = (frame_height_q > MAX_FRAME) ? MAX_FRAME : frame_height_q;
		r_sat = (disc_radius > MAX_RADIUS) ? MAX_RADIUS : disc_radius;
		cx_s = {{2{ctr_x[12]}}, ctr_x};
		cy_s = {{2{ctr_y[12]}}, ctr_y};
		rs_s = {8'd0, r_sat};
		ws_s = {3'd0, w_eff};
		hs_s = {3'd0, h_eff};
		cull = (r_sat == 7'd0) || (cx_s < -rs_s) || (cx_s >= ws_s + rs_s) ||
			(cy_s < -rs_s) || (cy_s >= hs_s + rs_s);

		dx_s = $signed({1'b0, scan_col_q}) - $signed({2'b00, body_radius_q});
		dy_s = $signed({1'b0, scan_row_q}) - $signed({2'b00, body_radius_q});
		x_s = {body_col_q[12], body_col_q} + {{5{dx_s[8]}}, dx_s};
		y_s = {body_row_q[12], body_row_q} + {{5{dy_s[8]}}, dy_s};
		x_in = !x_s[13] && (x_s[12:0] < {1'b0, w_eff});
		y_in = !y_s[13] && (y_s[12:0] < {1'b0, h_eff});
		adx = dx_s[8] ? 7'(-dx_s) : dx_s[6:0];
		ady = dy_s[8] ? 7'(-dy_s) : dy_s[6:0];
		col_last = (scan_col_q == {body_radius_q, 1'b0});
		row_last = (scan_row_q == {body_radius_q, 1'b0});
	end

	always_comb begin
		case (phase_q)
			PH_R2: begin
				mul_a = {10'd0, body_radius_q};
				mul_b = {9'd0, body_radius_q};
			end
			PH_DX2: begin
				mul_a = {10'd0, dx_q};
				mul_b = {9'd0, dx_q};
			end
			PH_DY2: begin
				mul_a = {10'd0, dy_q};
				mul_b = {9'd0, dy_q};
			end
			PH_SH: begin
				mul_a = div_q[16:0];
				mul_b = SH_GAIN;
			end
			PH_ST: begin
				mul_a = shade_q;
				mul_b = ST_GAIN;
			end
			PH_CR: begin
				mul_a = shade_q;
				mul_b = {8'd0, body_red_q};
			end
			PH_CG: begin
				mul_a = shade_q;
				mul_b = {8'd0, body_green_q};
			end
			PH_CB: begin
				mul_a = shade_q;
				mul_b = {8'd0, body_blue_q};
			end
			default: begin
				mul_a = 17'd0;
				mul_b = 16'd0;
			end
		endcase
		mul_p = {16'd0, mul_a} * {17'd0, mul_b};
		ch_sum = mul_p[24:0] + RND_HALF;
		ch_val = ch_sum[24] ? 8'hFF : ch_sum[23:16];
	end

	always_comb begin
		sq_rem_n = {sq_rem_q[23:0], rad_q[45:44]};
		sq_trial = {1'b0, root_q, 2'b01};
		sq_ge    = (sq_rem_n >= sq_trial);
		root_n   = {root_q[21:0], sq_ge};
		dv_rem_n = {dv_rem_q, div_q[22]};
		dv_ge    = (dv_rem_n >= {1'b0, body_radius_q});
		div_n    = {div_q[21:0], dv_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			scan_col_q    <= 8'd0;
			scan_row_q    <= 8'd0;
			body_col_q    <= 13'd0;
			body_row_q    <= 13'd0;
			body_radius_q <= 7'd0;
			body_star_q   <= 1'b0;
			body_red_q    <= 8'd0;
			body_green_q  <= 8'd0;
			body_blue_q   <= 8'd0;
			scan_active_q <= 1'b0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (in_take) begin
						if (cmd == CMD_LOAD) begin
							body_col_q    <= ctr_x;
							body_row_q    <= ctr_y;
							body_radius_q <= r_sat;
							body_star_q   <= is_star;
							body_red_q    <= red;
							body_green_q  <= green;
							body_blue_q   <= blue;
							scan_col_q    <= 8'd0;
							scan_row_q    <= 8'd0;
							scan_active_q <= !cull;
							res_fin_q     <= cull;
							res_we_q      <= 1'b0;
							phase_q       <= PH_DONE;
						end else if (!scan_active_q) begin
							res_fin_q <= 1'b1;
							res_we_q  <= 1'b0;
							phase_q   <= PH_DONE;
						end else begin
							dx_q      <= adx;
							dy_q      <= ady;
							res_x_q   <= x_s[10:0];
							res_y_q   <= y_s[10:0];
							inframe_q <= x_in && y_in;
							res_fin_q <= col_last && row_last;
							if (col_last) begin
								scan_col_q <= 8'd0;
								if (row_last) begin
									scan_row_q    <= 8'd0;
									scan_active_q <= 1'b0;
								end else begin
									scan_row_q <= scan_row_q + 8'd1;
								end
							end else begin
								scan_col_q <= scan_col_q + 8'd1;
							end
							phase_q <= PH_R2;
						end
					end
				end
				PH_R2: begin
					acc_q   <= $signed({2'b00, mul_p[13:0]});
					phase_q <= PH_DX2;
				end
				PH_DX2: begin
					acc_q   <= acc_q - $signed({2'b00, mul_p[13:0]});
					phase_q <= PH_DY2;
				end
				PH_DY2: begin
					acc_q   <= acc_q - $signed({2'b00, mul_p[13:0]});
					phase_q <= PH_CHK;
				end
				PH_CHK: begin
					if (!inframe_q || acc_q[15]) begin
						res_we_q <= 1'b0;
						phase_q  <= PH_DONE;
					end else begin
						rad_q    <= {acc_q[13:0], 32'd0};
						sq_rem_q <= 26'd0;
						root_q   <= 23'd0;
						cnt_q    <= LAST_STEP;
						phase_q  <= PH_SQRT;
					end
				end
				PH_SQRT: begin
					rad_q    <= {rad_q[43:0], 2'b00};
					sq_rem_q <= sq_ge ? (sq_rem_n - sq_trial) : sq_rem_n;
					root_q   <= root_n;
					if (cnt_q == 5'd0) begin
						div_q    <= root_n;
						dv_rem_q <= 7'd0;
						cnt_q    <= LAST_STEP;
						phase_q  <= PH_DIV;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				PH_DIV: begin
					dv_rem_q <= dv_ge ? 7'(dv_rem_n - {1'b0, body_radius_q}) : dv_rem_n[6:0];
					div_q    <= div_n;
					if (cnt_q == 5'd0) begin
						phase_q <= PH_SH;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				PH_SH: begin
					shade_q <= SH_BASE + {1'b0, mul_p[31:16]};
					phase_q <= body_star_q ? PH_ST : PH_CR;
				end
				PH_ST: begin
					shade_q <= ST_BASE + {1'b0, mul_p[31:16]};
					phase_q <= PH_CR;
				end
				PH_CR: begin
					res_red_q <= ch_val;
					phase_q   <= PH_CG;
				end
				PH_CG: begin
					res_green_q <= ch_val;
					phase_q     <= PH_CB;
				end
				PH_CB: begin
					res_blue_q <= ch_val;
					res_we_q   <= 1'b1;
					phase_q    <= PH_DONE;
				end
				PH_DONE: begin
					if (out_load) begin
						phase_q <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			write_enable_q <= res_we_q;
			pixel_x_q      <= res_we_q ? res_x_q : 11'd0;
			pixel_y_q      <= res_we_q ? res_y_q : 11'd0;
			out_red_q      <= res_we_q ? res_red_q : 8'd0;
			out_green_q    <= res_we_q ? res_green_q : 8'd0;
			out_blue_q     <= res_we_q ? res_blue_q : 8'd0;
			star_pixel_q   <= res_we_q && body_star_q;
			finished_q     <= res_fin_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign write_enable = write_enable_q;
	assign pixel_x      = pixel_x_q;
	assign pixel_y      = pixel_y_q;
	assign out_red      = out_red_q;
	assign out_green    = out_green_q;
	assign out_blue     = out_blue_q;
	assign star_pixel   = star_pixel_q;
	assign finished     = finished_q;

endmodule

`default_nettype wire

[verif/tb_shaded_disc_rasterizer_core.sv]
// Testbench for the shaded disc rasterizer core with a scan and shading predictor.
`timescale 1ns / 1ps

module tb_shaded_disc_rasterizer_core;
	import sdr_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic        write_enable;
		logic [10:0] pixel_x;
		logic [10:0] pixel_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        star;
		logic        finished;
	} raster_out_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [11:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               cmd;
	logic signed [12:0] ctr_x;
	logic signed [12:0] ctr_y;
	logic [6:0]         disc_radius;
	logic               is_star;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic               out_valid;
	logic               out_stall;
	logic               write_enable;
	logic [10:0]        pixel_x;
	logic [10:0]        pixel_y;
	logic [7:0]         out_red;
	logic [7:0]         out_green;
	logic [7:0]         out_blue;
	logic               star_pixel;
	logic               finished;

	// predictor state
	logic [11:0] frame_w;
	logic [11:0] frame_h;
	int          scan_col;
	int          scan_row;
	int          body_col;
	int          body_row;
	int          body_rad;
	logic        body_star;
	logic        scan_on;
	logic [7:0]  body_r;
	logic [7:0]  body_g;
	logic [7:0]  body_b;

	raster_out_t raster_q[$];
	raster_out_t next_px;

	int error_count;
	int items_sent;
	int send_idle_pct;
	int recv_stall_pct;
	int cycle_count = 0;

	shaded_disc_rasterizer_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic bit chance(input int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic int eff_frame(input logic [11:0] v);
		return (v > MAX_FRAME) ? int'(MAX_FRAME) : int'(v);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= n) root = trial;
		end
		return root;
	endfunction

	function automatic logic [7:0] shade_chan(input logic [7:0] base,
			input longint unsigned shade);
		longint unsigned v;
		v = (base * shade + RND_HALF) >> 16;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic void raster_predict(input logic c, input logic signed [12:0] cx,
			input logic signed [12:0] cy, input logic [6:0] rad, input logic st,
			input logic [7:0] rr, input logic [7:0] gg, input logic [7:0] bb);
		raster_out_t res;
		int w, h, side, dx, dy, px, py, d2, r2;
		longint unsigned q, shade;
		res = '0;
		w = eff_frame(frame_w);
		h = eff_frame(frame_h);
		if (c == CMD_LOAD) begin
			body_rad = (rad > MAX_RADIUS) ? int'(MAX_RADIUS) : int'(rad);
			body_col = cx;
			body_row = cy;
			body_star = st;
			body_r = rr;
			body_g = gg;
			body_b = bb;
			scan_col = 0;
			scan_row = 0;
			scan_on = !(body_rad == 0 || body_col < -body_rad || body_col >= w + body_rad
				|| body_row < -body_rad || body_row >= h + body_rad);
			res.finished = !scan_on;
		end else if (!scan_on) begin
			res.finished = 1'b1;
		end else begin
			side = 2 * body_rad + 1;
			dx = scan_col - body_rad;
			dy = scan_row - body_rad;
			px = body_col + dx;
			py = body_row + dy;
			d2 = dx * dx + dy * dy;
			r2 = body_rad * body_rad;
			if (px >= 0 && px < w && py >= 0 && py < h && d2 <= r2) begin
				q = int_sqrt(longint'(r2 - d2) << 32) / body_rad;
				shade = SH_BASE + ((SH_GAIN * q) >> 16);
				if (body_star) shade = ST_BASE + ((ST_GAIN * shade) >> 16);
				res.write_enable = 1'b1;
				res.pixel_x = px[10:0];
				res.pixel_y = py[10:0];
				res.red = shade_chan(body_r, shade);
				res.green = shade_chan(body_g, shade);
				res.blue = shade_chan(body_b, shade);
				res.star = body_star;
			end
			scan_col++;
			if (scan_col >= side) begin
				scan_col = 0;
				scan_row++;
				if (scan_row >= side) begin
					scan_row = 0;
					scan_on = 1'b0;
					res.finished = 1'b1;
				end
			end
		end
		raster_q.insert(raster_q.size(), res);
	endfunction

	function automatic logic [7:0] pick_chan();
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 15) return 8'd0;
		if (roll < 30) return 8'd255;
		return 8'($urandom_range(255, 0));
	endfunction

	function automatic void cmp_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d, actual %0d", $time, fname, want, got);
			error_count++;
		end
	endfunction

	always @(negedge clk) out_stall = chance(recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (raster_q.size() == 0) begin
				$display("%0t ns: result transfer with nothing pending", $time);
				error_count++;
			end else begin
				next_px = raster_q.pop_front();
				cmp_field("write_enable", next_px.write_enable, write_enable);
				cmp_field("pixel_x", next_px.pixel_x, pixel_x);
				cmp_field("pixel_y", next_px.pixel_y, pixel_y);
				cmp_field("out_red", next_px.red, out_red);
				cmp_field("out_green", next_px.green, out_green);
				cmp_field("out_blue", next_px.blue, out_blue);
				cmp_field("star_pixel", next_px.star, star_pixel);
				cmp_field("finished", next_px.finished, finished);
			end
		end
	end

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct = 85;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 85;
			end
			default: begin
				send_idle_pct = 17;
				recv_stall_pct = 17;
			end
		endcase
	endtask

	task automatic send_item(input logic c, input logic signed [12:0] cx,
			input logic signed [12:0] cy, input logic [6:0] rad, input logic st,
			input logic [7:0] rr, input logic [7:0] gg, input logic [7:0] bb);
		@(negedge clk);
		while (chance(send_idle_pct)) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		cmd = c;
		ctr_x = cx;
		ctr_y = cy;
		disc_radius = rad;
		is_star = st;
		red = rr;
		green = gg;
		blue = bb;
		do @(posedge clk); while (in_stall !== 1'b0);
		raster_predict(c, cx, cy, rad, st, rr, gg, bb);
		items_sent++;
	endtask

	task automatic send_steps(input int n);
		logic [31:0] a, b;
		repeat (n) begin
			a = $urandom;
			b = $urandom;
			send_item(CMD_STEP, a[12:0], a[25:13], b[6:0], b[7], b[15:8], b[23:16],
				{a[31:26], b[31:30]});
		end
	endtask

	task automatic drain_results(input int extra);
		@(negedge clk);
		in_valid = 1'b0;
		while (raster_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == CFG_FRAME_WIDTH) frame_w = val;
		else if (idx == CFG_FRAME_HEIGHT) frame_h = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_directed_cases();
		drain_results(8);
		set_idle(IDLE_NONE);
		// step with no body loaded
		send_steps(1);
		// culled on each side and with a zero radius
		send_item(CMD_LOAD, 13'h1000, 13'sd90, 7'd1, 1'b0, 8'd255, 8'd255, 8'd255);
		send_item(CMD_LOAD, 13'sd4095, 13'sd90, 7'd5, 1'b1, 8'd1, 8'd2, 8'd3);
		send_item(CMD_LOAD, 13'sd100, 13'sd182, 7'd2, 1'b0, 8'd10, 8'd20, 8'd30);
		send_item(CMD_LOAD, 13'sd100, -13'sd3, 7'd2, 1'b0, 8'd10, 8'd20, 8'd30);
		send_item(CMD_LOAD, 13'sd50, 13'sd50, 7'd0, 1'b0, 8'd100, 8'd100, 8'd100);
		// radius saturates, first position off-frame
		send_item(CMD_LOAD, -13'sd96, 13'sd50, 7'd127, 1'b1, 8'd90, 8'd80, 8'd70);
		send_steps(1);
		// star clipped at the top-left corner, full scan, then idle step
		send_item(CMD_LOAD, 13'sd0, 13'sd0, 7'd1, 1'b1, 8'd255, 8'd0, 8'd255);
		send_steps(10);
		// planet clipped at the bottom-right corner
		send_item(CMD_LOAD, 13'sd319, 13'sd179, 7'd1, 1'b0, 8'd128, 8'd1, 8'd255);
		send_steps(9);
	endtask

	task automatic test_large_body();
		drain_results(8);
		set_idle(IDLE_BOTH);
		send_item(CMD_LOAD, 13'sd160, 13'sd96, 7'd96, 1'b0, 8'd255, 8'd127, 8'd64);
		// hold the sender until every pending result is back
		drain_results(0);
		send_steps(97);
		send_item(CMD_LOAD, 13'sd60, 13'sd96, 7'd127, 1'b1, 8'd200, 8'd100, 8'd50);
		send_steps(97);
	endtask

	task automatic test_random_bodies(input logic [11:0] width, input logic [11:0] height,
			input idle_mode_t mode, input int n_items);
		int stop_at, pick, rad_i, re, scan_len, n_steps, x_i, y_i;
		logic [31:0] rnd;
		logic [12:0] cx_b, cy_b;
		drain_results(8);
		write_reg(CFG_FRAME_WIDTH, width);
		write_reg(CFG_FRAME_HEIGHT, height);
		set_idle(mode);
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99, 0);
			if (pick == 99) rad_i = 0;
			else if (pick < 85) rad_i = $urandom_range(3, 1);
			else if (pick < 97) rad_i = $urandom_range(8, 4);
			else rad_i = $urandom_range(127, 9);
			re = (rad_i > MAX_RADIUS) ? int'(MAX_RADIUS) : rad_i;
			rnd = $urandom;
			if (chance(12)) begin
				cx_b = rnd[12:0];
				cy_b = rnd[25:13];
			end else begin
				x_i = int'($urandom_range(eff_frame(frame_w) + 2 * re + 3, 0)) - re - 2;
				y_i = int'($urandom_range(eff_frame(frame_h) + 2 * re + 3, 0)) - re - 2;
				cx_b = x_i[12:0];
				cy_b = y_i[12:0];
			end
			send_item(CMD_LOAD, cx_b, cy_b, rad_i[6:0], rnd[26], pick_chan(), pick_chan(),
				pick_chan());
			scan_len = (2 * re + 1) * (2 * re + 1);
			if (re > 8) n_steps = $urandom_range(60, 1);
			else if (chance(10)) n_steps = $urandom_range(scan_len - 1, 0);
			else n_steps = scan_len + $urandom_range(2, 0);
			if (n_steps > stop_at - items_sent) n_steps = stop_at - items_sent;
			send_steps(n_steps);
			if (chance(2)) drain_results(0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		ctr_x = '0;
		ctr_y = '0;
		disc_radius = '0;
		is_star = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		out_stall = 1'b0;
		error_count = 0;
		items_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		frame_w = FRAME_WIDTH_RST;
		frame_h = FRAME_HEIGHT_RST;
		scan_col = 0;
		scan_row = 0;
		body_col = 0;
		body_row = 0;
		body_rad = 0;
		body_star = 1'b0;
		scan_on = 1'b0;
		body_r = '0;
		body_g = '0;
		body_b = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_large_body();
		test_random_bodies(12'd320, 12'd180, IDLE_NONE, 170);
		test_random_bodies(12'd1, 12'd1, IDLE_SEND, 60);
		test_random_bodies(12'd4095, 12'd4095, IDLE_RECV, 160);
		test_random_bodies(12'd0, 12'd0, IDLE_BOTH, 50);
		test_random_bodies(12'd2048, 12'd2048, IDLE_BOTH, 120);
		test_random_bodies(12'($urandom_range(64, 16)), 12'($urandom_range(48, 12)),
			IDLE_SEND, 120);
		test_random_bodies(12'd2047, 12'd3, IDLE_RECV, 100);
		test_random_bodies(12'd320, 12'd180, IDLE_NONE, 145);
		drain_results(80);

		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/sdr_pkg.sv
hw/rtl/shaded_disc_rasterizer_core.sv
verif/tb_shaded_disc_rasterizer_core.sv
